[hdl/order_statistic_set_assert.svh]
// assertion macros used by the checker file oss_chk.sv
`ifndef ORDER_STATISTIC_SET_ASSERT_SVH
`define ORDER_STATISTIC_SET_ASSERT_SVH

// same-cycle implication, held off while reset is low
`define OSS_ASSERT_IMPLY(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("oss check failed");

// implication checked in the next cycle
`define OSS_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("oss check failed");

// delayed implication, checked later than OSS_ASSERT_NEXT
`define OSS_ASSERT_NEXT2(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> ##1 (b)) \
        else $error("oss check failed");

`endif

[hdl/oss_pkg.sv]
// shared types and constants of the order statistic set
package oss_pkg;

    localparam int OSS_CAPACITY = 64;
    localparam int KEY_W        = 31;
    localparam int VALUE_W      = 32;
    localparam int RANK_W       = 6;
    localparam int IN_TDATA_W   = 40;
    localparam int OUT_TDATA_W  = 32;
    localparam int OUT_TUSER_W  = 2;

    // update command broadcast to every cell
    typedef struct packed {
        logic             ins;
        logic             ers;
        logic [KEY_W-1:0] key;
    } t_cmd;

    // what a cell shows its neighbors
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             occ;
        logic             lt;
    } t_link;

endpackage

[hdl/oss_cell.sv]
// one slot of the sorted key chain
module oss_cell
    import oss_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cmd  i_cmd,
    input  t_link i_prev,
    input  t_link i_next,
    output t_link o_link,
    output logic  o_eq
);

    logic [KEY_W-1:0] r_key;
    logic [KEY_W-1:0] n_key;
    logic             r_occ;
    logic             n_occ;
    logic             lt;

    assign lt     = r_occ && (r_key < i_cmd.key);
    assign o_eq   = r_occ && (r_key == i_cmd.key);
    assign o_link = '{key: r_key, occ: r_occ, lt: lt};

    always_comb begin
        n_key = r_key;
        n_occ = r_occ;
        if (i_cmd.ins && !lt) begin
            // slots at or above the insert point move up by one
            n_key = i_prev.lt ? i_cmd.key : i_prev.key;
            n_occ = r_occ | i_prev.occ;
        end else if (i_cmd.ers && !lt) begin
            // slots at or above the erased key pull down from above
            n_key = i_next.key;
            n_occ = i_next.occ;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else begin
            r_occ <= n_occ;
        end
    end

endmodule

[hdl/order_statistic_set.sv]
// order statistic set: sorted cell chain with rank lookup
//
// Keeps up to CAPACITY distinct 31-bit keys in ascending order, one per cell.
// Input word on the s_axis side: tdata carries signed_value and rank. A
// non-negative value inserts that key (duplicates ignored), a negative value
// erases its magnitude (missing keys ignored). After the update the word on
// the m_axis side returns the rank-th smallest key, counting from zero, with
// a rank error flag and a full drop flag in tuser.
// Timing: an accepted word updates every cell in parallel at its accept
// edge and sets a pending flag; the result is registered into the output
// register once that register is free. The rank lookup and the update
// are separate stages, so a word may be accepted every cycle while the
// output register is free or being drained.
// Reset: synchronous, active low; the set is empty afterwards and no result
// is pending.
// Stall: when the receiver holds tready low with a result waiting and a
// second result pending, s_axis_tready drops and the cells hold their keys.
module order_statistic_set
    import oss_pkg::*;
#(
    parameter int CAPACITY = OSS_CAPACITY
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [31:0] signed_value, [37:32] rank, [39:38] zero
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [30:0] kth_key, [31] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // [0] rank_error, [1] full_drop
    output logic [OUT_TUSER_W-1:0] m_axis_tuser
);

    logic                 in_acc;
    logic                 out_free;
    logic [VALUE_W-1:0]   value;
    logic [RANK_W-1:0]    rank;
    logic [VALUE_W-1:0]   mag;
    logic                 is_erase;
    logic                 present;
    logic                 full;
    t_cmd                 cmd;
    t_link                links [CAPACITY];
    logic [CAPACITY-1:0]  eqs;
    logic [CAPACITY-1:0]  sel;
    logic [KEY_W-1:0]     pick_key;
    logic                 pick_hit;

    logic                 r_pend;
    logic [RANK_W-1:0]    r_rank;
    logic                 r_drop;
    logic                 r_out_valid;
    logic [KEY_W-1:0]     r_out_key;
    logic                 r_out_err;
    logic                 r_out_drop;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_pend || out_free;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    assign value    = s_axis_tdata[VALUE_W-1:0];
    assign rank     = s_axis_tdata[VALUE_W +: RANK_W];
    assign mag      = (~value) + 32'd1;
    assign is_erase = value[VALUE_W-1];

    assign present = |eqs;
    assign full    = links[CAPACITY-1].occ;

    always_comb begin
        cmd.key = is_erase ? mag[KEY_W-1:0] : value[KEY_W-1:0];
        cmd.ins = in_acc && !is_erase && !present && !full;
        // most negative value has no 31-bit magnitude
        cmd.ers = in_acc && is_erase && !mag[VALUE_W-1] && present;
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            t_link prv;
            t_link nxt;
            if (g == 0) begin : g_head
                assign prv = '{key: cmd.key, occ: 1'b1, lt: 1'b0};
            end else begin : g_mid
                assign prv = links[g-1];
            end
            if (g == CAPACITY - 1) begin : g_tail
                assign nxt = '{key: '0, occ: 1'b0, lt: 1'b0};
            end else begin : g_body
                assign nxt = links[g+1];
            end
            oss_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_cmd   (cmd),
                .i_prev  (prv),
                .i_next  (nxt),
                .o_link  (links[g]),
                .o_eq    (eqs[g])
            );
            assign sel[g] = (32'(r_rank) == 32'(g)) && links[g].occ;
        end
    endgenerate

    // one-hot pick of the ranked slot after the update has settled
    always_comb begin
        pick_key = '0;
        pick_hit = 1'b0;
        for (int i = 0; i < CAPACITY; i++) begin
            pick_key = pick_key | (sel[i] ? links[i].key : '0);
            pick_hit = pick_hit | sel[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rank <= rank;
            r_drop <= !is_erase && !present && full;
        end
        if (r_pend && out_free) begin
            r_out_key  <= pick_key;
            r_out_err  <= !pick_hit;
            r_out_drop <= r_drop;
        end
        if (!i_rst_n) begin
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_pend <= 1'b1;
            end else if (out_free) begin
                r_pend <= 1'b0;
            end
            if (r_pend && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_key};
    assign m_axis_tuser  = {r_out_drop, r_out_err};

endmodule

[hdl/oss_chk.sv]
// port-level checks on the order statistic set
`include "order_statistic_set_assert.svh"

module oss_chk
    import oss_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [OUT_TUSER_W-1:0] m_axis_tuser
);

    `OSS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `OSS_ASSERT_IMPLY(a_err_zero, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == '0)
    `OSS_ASSERT_IMPLY(a_pad_zero, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[OUT_TDATA_W-1] == 1'b0)
    `OSS_ASSERT_NEXT2(a_result_due, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, m_axis_tvalid)

endmodule

bind order_statistic_set oss_chk u_oss_chk (.*);
